[design/wsta_pkg.sv]
// shared types and constants of the weighted server task assigner
`timescale 1ns / 1ps

package wsta_pkg;

  // field widths
  localparam int unsigned CmdW    = 1;
  localparam int unsigned SrvW    = 4;
  localparam int unsigned WeightW = 20;
  localparam int unsigned DurW    = 20;
  localparam int unsigned TaskW   = 32;
  localparam int unsigned TimeW   = 48;
  localparam int unsigned CfgW    = 5;

  // reset value of the server count register
  localparam logic [CfgW-1:0] CfgReset = 5'd16;

  // command codes
  localparam logic [CmdW-1:0] CmdLoad = 1'b0;
  localparam logic [CmdW-1:0] CmdTask = 1'b1;

  // input item
  typedef struct packed {
    logic [CmdW-1:0]    command;
    logic [SrvW-1:0]    server_index;
    logic [WeightW-1:0] weight;
    logic [DurW-1:0]    duration;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [SrvW-1:0]  assigned_server;
    logic [TaskW-1:0] task_number;
  } out_item_t;

  // controller to datapath commands (read address travels separately)
  typedef struct packed {
    logic load_wt;
    logic start_task;
    logic rd_en;
    logic finish;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

[design/weighted_server_task_assigner.sv]
// top level of the weighted server task assigner
//
//   channel   direction  handshake                    payload
//   in        input      in_valid_i / in_stall_o      wsta_pkg::in_item_t
//   out       output     out_valid_o / out_stall_i    wsta_pkg::out_item_t
//   cfg       input      cfg_we_i                     servers_in_use (5 bits)
//
// a load is written when it is taken; a task scans n servers, n the active server count,
// with one store read per cycle over all active servers, then a drain state for
// the last compare, and a write-back state.
// reset clears the busy-until valid bits, the task counter and the control state.
// a task waits in write-back while the held result is stalled; a new item can
// be taken while a finished result waits in the output register.
`timescale 1ns / 1ps

module weighted_server_task_assigner #(
  parameter int unsigned NUM_SERVERS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  wsta_pkg::in_item_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output wsta_pkg::out_item_t        out_data_o,
  input  logic                       cfg_we_i,
  input  logic [wsta_pkg::CfgW-1:0]  cfg_wdata_i
);

  localparam int unsigned IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;

  wsta_pkg::ctrl_cmd_t  cmd;
  wsta_pkg::dp_status_t status;
  logic [IDX_W-1:0]     rd_addr;

  // controller
  wsta_ctrl #(
    .NUM_SERVERS (NUM_SERVERS),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_data_i.command),
    .in_stall_o   (in_stall_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .status_i     (status),
    .cmd_o        (cmd),
    .rd_addr_o    (rd_addr)
  );

  // datapath
  wsta_dp #(
    .NUM_SERVERS (NUM_SERVERS),
    .IDX_W       (IDX_W)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .rd_addr_i   (rd_addr),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[design/wsta_ctrl.sv]
// controller sequencing weight loads and the per-task server scan
`timescale 1ns / 1ps

module wsta_ctrl #(
  parameter int unsigned NUM_SERVERS = 16,
  parameter int unsigned IDX_W       = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [wsta_pkg::CmdW-1:0]  in_command_i,
  output logic                       in_stall_o,
  input  logic                       cfg_we_i,
  input  logic [wsta_pkg::CfgW-1:0]  cfg_wdata_i,
  input  wsta_pkg::dp_status_t       status_i,
  output wsta_pkg::ctrl_cmd_t        cmd_o,
  output logic [IDX_W-1:0]           rd_addr_o
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    DRAIN,
    FINISH
  } state_e;

  state_e                    state_q, state_d;
  logic [IDX_W-1:0]          cnt_q, cnt_d;
  logic [wsta_pkg::CfgW-1:0] srv_cnt_q;
  logic [IDX_W-1:0]          last_idx;
  logic                      in_xfer;

  // server count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srv_cnt_q <= wsta_pkg::CfgReset;
    end else if (cfg_we_i) begin
      srv_cnt_q <= cfg_wdata_i;
    end
  end

  // last scanned index, count clamped to 1 .. NUM_SERVERS
  always_comb begin
    if (srv_cnt_q == '0) begin
      last_idx = '0;
    end else if (32'(srv_cnt_q) > NUM_SERVERS) begin
      last_idx = IDX_W'(NUM_SERVERS - 1);
    end else begin
      last_idx = IDX_W'(srv_cnt_q - 1'b1);
    end
  end

  assign in_stall_o = (state_q != IDLE);
  assign in_xfer    = (state_q == IDLE) && in_valid_i;
  assign rd_addr_o  = cnt_q;

  // command decode
  always_comb begin
    cmd_o            = '0;
    cmd_o.load_wt    = in_xfer && (in_command_i == wsta_pkg::CmdLoad);
    cmd_o.start_task = in_xfer && (in_command_i == wsta_pkg::CmdTask);
    cmd_o.rd_en      = (state_q == SCAN);
    cmd_o.finish     = (state_q == FINISH) && status_i.out_free;
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      IDLE: begin
        cnt_d = '0;
        if (in_xfer && (in_command_i == wsta_pkg::CmdTask)) begin
          state_d = SCAN;
        end
      end
      SCAN: begin
        if (cnt_q == last_idx) begin
          state_d = DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      DRAIN: begin
        state_d = FINISH;
      end
      FINISH: begin
        if (status_i.out_free) begin
          state_d = IDLE;
        end
      end
      default: begin
        state_d = IDLE;
      end
    endcase
  end

  // state and scan counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // scan address never passes the last active server
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SCAN) |-> (cnt_q <= last_idx))
    else $error("scan address beyond active servers");

  // a task transfer always starts the scan at server zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start_task |=> (state_q == SCAN) && (cnt_q == '0))
    else $error("task did not start a scan");

  // the scan always drains before the write-back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FINISH) && !$past(state_q == FINISH) |-> $past(state_q == DRAIN))
    else $error("write-back without drain");

endmodule

[design/wsta_dp.sv]
// datapath: weight and busy-until stores, candidate compare, write-back, result register
`timescale 1ns / 1ps

module wsta_dp #(
  parameter int unsigned NUM_SERVERS = 16,
  parameter int unsigned IDX_W       = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wsta_pkg::in_item_t    in_data_i,
  input  wsta_pkg::ctrl_cmd_t   cmd_i,
  input  logic [IDX_W-1:0]      rd_addr_i,
  output wsta_pkg::dp_status_t  status_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output wsta_pkg::out_item_t   out_data_o
);

  localparam int unsigned WW = wsta_pkg::WeightW;
  localparam int unsigned TW = wsta_pkg::TimeW;

  // stores
  logic [WW-1:0]          weight_mem [NUM_SERVERS];
  logic [TW-1:0]          busy_mem   [NUM_SERVERS];
  logic [NUM_SERVERS-1:0] busy_vld_q;

  // read stage
  logic                   cmp_v_q;
  logic [IDX_W-1:0]       rd_idx_q;
  logic [WW-1:0]          rd_w_q;
  logic [TW-1:0]          rd_busy_q;
  logic                   rd_bvld_q;

  // per-task registers
  logic [wsta_pkg::DurW-1:0]  dur_q;
  logic [wsta_pkg::TaskW-1:0] task_cnt_q;
  logic                       found_free_q;
  logic [WW-1:0]              free_w_q;
  logic [IDX_W-1:0]           free_idx_q;
  logic                       e_have_q;
  logic [TW-1:0]              e_busy_q;
  logic [WW-1:0]              e_w_q;
  logic [IDX_W-1:0]           e_idx_q;

  // result register
  logic                 out_valid_q;
  wsta_pkg::out_item_t  out_data_q;

  logic [TW-1:0]    now;
  logic [TW-1:0]    eff_busy;
  logic             is_free;
  logic             take_free;
  logic             take_early;
  logic [IDX_W-1:0] pick;
  logic [TW-1:0]    start_time;
  logic [TW:0]      sum;
  logic [TW-1:0]    new_busy;
  logic             ld_ok;

  assign now      = TW'(task_cnt_q);
  assign eff_busy = rd_bvld_q ? rd_busy_q : '0;
  assign is_free  = (eff_busy <= now);
  assign ld_ok    = (32'(in_data_i.server_index) < NUM_SERVERS);

  // candidate compares
  assign take_free  = is_free && (!found_free_q || (rd_w_q < free_w_q));
  assign take_early = !e_have_q || (eff_busy < e_busy_q) ||
                      ((eff_busy == e_busy_q) && (rd_w_q < e_w_q));

  // chosen server and its new busy-until time, saturating
  assign pick       = found_free_q ? free_idx_q : e_idx_q;
  assign start_time = found_free_q ? now : e_busy_q;
  assign sum        = {1'b0, start_time} + (TW + 1)'(dur_q);
  assign new_busy   = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;

  // weight store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wt && ld_ok) begin
      weight_mem[IDX_W'(in_data_i.server_index)] <= in_data_i.weight;
    end
    if (cmd_i.rd_en) begin
      rd_w_q <= weight_mem[rd_addr_i];
    end
  end

  // busy-until store
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      busy_mem[pick] <= new_busy;
    end
    if (cmd_i.rd_en) begin
      rd_busy_q <= busy_mem[rd_addr_i];
      rd_idx_q  <= rd_addr_i;
    end
  end

  // busy-until valid bits, an entry not yet written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_vld_q <= '0;
      rd_bvld_q  <= 1'b0;
      cmp_v_q    <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        busy_vld_q[pick] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_bvld_q <= busy_vld_q[rd_addr_i];
      end
      cmp_v_q <= cmd_i.rd_en;
    end
  end

  // candidate flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_free_q <= 1'b0;
      e_have_q     <= 1'b0;
    end else if (cmd_i.start_task) begin
      found_free_q <= 1'b0;
      e_have_q     <= 1'b0;
    end else if (cmp_v_q) begin
      if (take_free) begin
        found_free_q <= 1'b1;
      end
      if (take_early) begin
        e_have_q <= 1'b1;
      end
    end
  end

  // candidate payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_task) begin
      dur_q <= in_data_i.duration;
    end
    if (cmp_v_q && take_free) begin
      free_w_q   <= rd_w_q;
      free_idx_q <= rd_idx_q;
    end
    if (cmp_v_q && take_early) begin
      e_busy_q <= eff_busy;
      e_w_q    <= rd_w_q;
      e_idx_q  <= rd_idx_q;
    end
  end

  // task counter and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        task_cnt_q  <= task_cnt_q + 1'b1;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_q.assigned_server <= wsta_pkg::SrvW'(pick);
      out_data_q.task_number     <= task_cnt_q;
    end
  end

  // write-back never overwrites a result that is still held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten before transfer");

  // every write-back advances the task counter by one and presents a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_valid_q && (task_cnt_q == $past(task_cnt_q) + 1'b1))
    else $error("task counter or result out of step");

  // a write-back always has a candidate from the scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> e_have_q)
    else $error("write-back without candidate");

endmodule
